>>> rtl/core/cma_pkg.sv
`timescale 1ns / 1ps
package cma_pkg;

	// default build values
	localparam int MAX_HALF_DEF     = 31;
	localparam int SAMPLE_WIDTH_DEF = 16;

	// window size register
	localparam int CFG_W = 6;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SUM,
		ST_DIV,
		ST_EMIT
	} cma_state_t;

endpackage

>>> rtl/core/cma_if.sv
`timescale 1ns / 1ps
// input sample channel
interface cma_in_if #(
	parameter int SAMPLE_WIDTH = cma_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           end_of_sequence;

	modport source (output valid, output sample, output end_of_sequence, input ready);
	modport sink   (input valid, input sample, input end_of_sequence, output ready);
endinterface

// smoothed result channel
interface cma_out_if #(
	parameter int SAMPLE_WIDTH = cma_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] smoothed;
	logic                           last_of_run;

	modport source (output valid, output smoothed, output last_of_run, input ready);
	modport sink   (input valid, input smoothed, input last_of_run, output ready);
endinterface

>>> rtl/core/cma_ram.sv
`timescale 1ns / 1ps
module cma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 63
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/cma_div.sv
`timescale 1ns / 1ps
module cma_div #(
	parameter int SUM_W = 22,
	parameter int CNT_W = 6,
	parameter int OUT_W = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0]        divisor,
	output logic                    done,
	output logic signed [OUT_W-1:0] quotient
);

	localparam int CW = $clog2(SUM_W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic             neg_q;

	logic [SUM_W-1:0] mag;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             ge;
	logic [CNT_W-1:0] rem_n;
	logic [SUM_W-1:0] quo_s;

	// magnitude of the dividend, one restoring step per cycle
	always_comb begin
		mag   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
		trial = {rem_q, quo_q[SUM_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
		rem_n = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		quo_s = neg_q ? (~quo_q + 1'b1) : quo_q;
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient and remainder shift
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			neg_q <= dividend[SUM_W-1];
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= rem_n;
		end
	end

	assign done     = done_q;
	assign quotient = quo_s[OUT_W-1:0];

endmodule

>>> rtl/core/centered_moving_average_top.sv
`timescale 1ns / 1ps
// Centered moving average with truncated edges.
// in_ch carries one sample and an end_of_sequence flag per transfer; out_ch
// carries the smoothed value and last_of_run. cfg_we/cfg_wdata write the
// window size (half width = size / 2, clamped to MAX_HALF); write it only
// while the block is idle.
// A sample that does not yet complete a window is stored and gives no result. Otherwise
// each result takes a setup step, reads and adds the n window samples from
// the ring memory (one read port), starts, runs and finishes the serial
// divider and loads the output register. A final sample produces
// min(h, count - 1) + 1 results back to back in that way.
// in_ch.ready is low from the accepting edge until the last result of that
// sample sits in the output register. The output register holds a result
// while out_ch.ready is low; the sequencer waits on it before loading the
// next one and accepts no new sample meanwhile.
// Reset clears the sequence count, the ring pointer, the output valid and
// sets the window size to 1; the ring contents are not cleared.
module centered_moving_average_top #(
	parameter int MAX_HALF     = cma_pkg::MAX_HALF_DEF,
	parameter int SAMPLE_WIDTH = cma_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [cma_pkg::CFG_W-1:0] cfg_wdata,
	cma_in_if.sink                  in_ch,
	cma_out_if.source               out_ch
);
	import cma_pkg::*;

	localparam int RING  = 2 * MAX_HALF + 1;
	localparam int AGE_W = $clog2(RING);
	localparam int CNT_W = $clog2(RING + 1);
	localparam int SUM_W = SAMPLE_WIDTH + CNT_W;
	localparam logic [CFG_W-1:0] MAX_HALF_C = CFG_W'(MAX_HALF);
	localparam logic [AGE_W-1:0] LAST_SLOT  = AGE_W'(RING - 1);
	localparam logic [CNT_W-1:0] RING_C     = CNT_W'(RING);

	cma_state_t state_q, state_d;

	logic [CFG_W-1:0] cfg_q;
	logic [AGE_W-1:0] wp_q;
	logic [CNT_W-1:0] seen_q;
	logic             out_vld_q;
	logic             rd_vld_s1;
	logic [CNT_W-1:0] rd_left_q;

	logic [AGE_W-1:0] half_q;
	logic [AGE_W-1:0] newest_q;
	logic [CNT_W-1:0] present_q;
	logic             eos_q;
	logic [AGE_W-1:0] c_q;
	logic [AGE_W-1:0] addr_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_hold_q;
	logic signed [SAMPLE_WIDTH-1:0] out_data_q;
	logic             out_last_q;

	logic             accept;
	logic [CFG_W-1:0] half_raw;
	logic [AGE_W-1:0] half_n;
	logic [CNT_W-1:0] present_n;
	logic [AGE_W-1:0] pm1_n;
	logic             emit_n;
	logic [AGE_W-1:0] lo;
	logic [AGE_W-1:0] hi_raw;
	logic [AGE_W-1:0] pm1;
	logic [AGE_W-1:0] hi;
	logic [CNT_W-1:0] count;
	logic [AGE_W:0]   start_wide;
	logic [AGE_W-1:0] start_addr;
	logic             sum_done;
	logic             out_free;
	logic             more;

	logic             ram_re;
	logic [SAMPLE_WIDTH-1:0] ram_rdata;
	logic             div_start;
	logic             div_done;
	logic signed [SAMPLE_WIDTH-1:0] div_quo;

	// sample ring
	cma_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(RING)
	) u_ring (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata (in_ch.sample),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// serial divider for the window average, divisor is the held window count
	cma_div #(
		.SUM_W(SUM_W),
		.CNT_W(CNT_W),
		.OUT_W(SAMPLE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_hold_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// accept decision and window bounds
	always_comb begin
		accept    = in_ch.valid && (state_q == ST_IDLE);
		half_raw  = cfg_q >> 1;
		half_n    = (half_raw > MAX_HALF_C) ? AGE_W'(MAX_HALF) : AGE_W'(half_raw);
		present_n = (seen_q == RING_C) ? seen_q : seen_q + 1'b1;
		pm1_n     = AGE_W'(present_n - 1'b1);
		emit_n    = in_ch.end_of_sequence || (present_n > CNT_W'(half_n));

		lo         = (c_q > half_q) ? c_q - half_q : '0;
		hi_raw     = c_q + half_q;
		pm1        = AGE_W'(present_q - 1'b1);
		hi         = (hi_raw > pm1) ? pm1 : hi_raw;
		count      = CNT_W'(hi) - CNT_W'(lo) + 1'b1;
		start_wide = (newest_q >= lo) ? {1'b0, newest_q} - {1'b0, lo}
		                              : {1'b0, newest_q} + (AGE_W+1)'(RING) - {1'b0, lo};
		start_addr = start_wide[AGE_W-1:0];

		sum_done = (rd_left_q == '0) && !rd_vld_s1;
		out_free = !out_vld_q || out_ch.ready;
		more     = eos_q && (c_q != '0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && emit_n) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_d = ST_SUM;
			end
			ST_SUM: begin
				if (sum_done) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = more ? ST_SETUP : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ch.ready = 1'b0;
		ram_re      = 1'b0;
		div_start   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
			end
			ST_SUM: begin
				ram_re    = rd_left_q != '0;
				div_start = sum_done;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cfg_q     <= CFG_RESET;
			wp_q      <= '0;
			seen_q    <= '0;
			out_vld_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rd_left_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (accept) begin
				wp_q   <= (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
				seen_q <= in_ch.end_of_sequence ? '0 : present_n;
			end
			if (state_q == ST_SETUP) begin
				rd_left_q <= count;
			end else if (ram_re) begin
				rd_left_q <= rd_left_q - 1'b1;
			end
			rd_vld_s1 <= ram_re;
			if (out_vld_q && out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			if (state_q == ST_EMIT && out_free) begin
				out_vld_q <= 1'b1;
			end
		end
	end

	// item and accumulator registers
	always_ff @(posedge clk) begin
		if (accept) begin
			half_q    <= half_n;
			newest_q  <= wp_q;
			present_q <= present_n;
			eos_q     <= in_ch.end_of_sequence;
			c_q       <= (in_ch.end_of_sequence && (pm1_n < half_n)) ? pm1_n : half_n;
		end
		if (state_q == ST_SETUP) begin
			addr_q     <= start_addr;
			sum_q      <= '0;
			cnt_hold_q <= count;
		end else begin
			if (ram_re) begin
				addr_q <= (addr_q == '0) ? LAST_SLOT : addr_q - 1'b1;
			end
			if (rd_vld_s1) begin
				sum_q <= sum_q + {{(SUM_W-SAMPLE_WIDTH){ram_rdata[SAMPLE_WIDTH-1]}}, ram_rdata};
			end
		end
		if (state_q == ST_EMIT && out_free) begin
			out_data_q <= div_quo;
			out_last_q <= eos_q && (c_q == '0);
			if (more) begin
				c_q <= c_q - 1'b1;
			end
		end
	end

	assign out_ch.valid       = out_vld_q;
	assign out_ch.smoothed    = out_data_q;
	assign out_ch.last_of_run = out_last_q;

endmodule

>>> rtl/core/cma_check.sv
`timescale 1ns / 1ps
module cma_check (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_eos,
	input logic out_valid,
	input logic out_ready
);

	// a pending result stays offered until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	// a final sample always produces work, so input must stall
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_eos |=> !in_ready)
		else $error("input ready right after final sample");

	// a new result only appears after the sequencer was busy
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while sequencer idle");

endmodule

bind centered_moving_average_top cma_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_eos    (in_ch.end_of_sequence),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;

	import cma_pkg::*;

	localparam int SW          = SAMPLE_WIDTH_DEF;
	localparam int HALF_LIMIT  = MAX_HALF_DEF;
	localparam int RING        = 2 * HALF_LIMIT + 1;
	localparam int SETTLE_WAIT = 120;

	typedef struct packed {
		logic signed [SW-1:0] smoothed;
		logic                 last_of_run;
	} smooth_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	cma_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
	cma_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

	centered_moving_average_top #(
		.MAX_HALF    (HALF_LIMIT),
		.SAMPLE_WIDTH(SW)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// smoothing state as the block should hold it
	logic signed [SW-1:0] ring_mem [RING];
	int                   ring_wr;
	int                   seq_count;
	logic [CFG_W-1:0]     window_reg;

	smooth_result_t expected_q [$];
	int             fail_count = 0;
	int             tx_idle_pct;
	int             rx_idle_pct;

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// run limit
	initial begin
		#30_000_000;
		$error("timeout with %0d results outstanding", expected_q.size());
		$display("*** FAILED ***");
		$finish;
	end

	// mean over the existing samples of the centered window, truncated toward zero
	function automatic logic signed [SW-1:0] window_mean(int newest, int center, int half,
		int present);
		int     lo;
		int     hi;
		longint acc;
		lo  = (center > half) ? center - half : 0;
		hi  = center + half;
		if (hi > present - 1)
			hi = present - 1;
		acc = 0;
		for (int age = lo; age <= hi; age++)
			acc += ring_mem[(newest + RING - age % RING) % RING];
		return SW'(acc / longint'(hi - lo + 1));
	endfunction

	// store one accepted sample and queue the averages it releases
	function automatic void predict_transfer(logic signed [SW-1:0] s, logic eos);
		int half;
		int newest;
		int present;
		int c;
		half = int'(window_reg) / 2;
		if (half > HALF_LIMIT)
			half = HALF_LIMIT;
		newest           = ring_wr;
		ring_mem[newest] = s;
		ring_wr          = (newest + 1) % RING;
		if (seq_count < RING)
			seq_count++;
		present = seq_count;
		if (eos) begin
			// flush every pending position, oldest first
			for (c = (half < present - 1) ? half : present - 1; c >= 0; c--)
				expected_q.push_back(smooth_result_t'{
					smoothed: window_mean(newest, c, half, present),
					last_of_run: (c == 0)});
			seq_count = 0;
		end else if (present > half) begin
			expected_q.push_back(smooth_result_t'{
				smoothed: window_mean(newest, half, half, present),
				last_of_run: 1'b0});
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		smooth_result_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result smoothed=%0d last_of_run=%0b",
					out_ch.smoothed, out_ch.last_of_run);
				fail_count++;
			end else begin
				exp_r = expected_q.pop_front();
				if (out_ch.smoothed !== exp_r.smoothed) begin
					$error("smoothed: expected %0d, got %0d", exp_r.smoothed, out_ch.smoothed);
					fail_count++;
				end
				if (out_ch.last_of_run !== exp_r.last_of_run) begin
					$error("last_of_run: expected %0b, got %0b", exp_r.last_of_run,
						out_ch.last_of_run);
					fail_count++;
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		out_ch.ready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	// one sample transfer, with random idle cycles ahead of it
	task automatic send_sample(input logic signed [SW-1:0] s, input logic eos);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.sample          <= s;
		in_ch.end_of_sequence <= eos;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_transfer(s, eos);
		@(negedge clk);
	endtask

	// stop sending, wait for every result, then let the block go quiet
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	task automatic write_window(input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		window_reg = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(7))
			0: return {1'b1, {(SW-1){1'b0}}};
			1: return {1'b0, {(SW-1){1'b1}}};
			default: return SW'($urandom);
		endcase
	endfunction

	// mostly narrow windows, a few of the widest
	function automatic logic [CFG_W-1:0] pick_window();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return CFG_W'($urandom_range(9));
		else if (r < 90)
			return CFG_W'($urandom_range(63, 10));
		else
			return CFG_W'($urandom_range(63, 62));
	endfunction

	// reset value of the window: samples pass straight through
	task automatic test_reset_window();
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd32767, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd0, 1'b1);
		settle();
	endtask

	task automatic test_zero_window();
		write_window(CFG_W'(0));
		send_sample(16'sd1, 1'b0);
		send_sample(-16'sd2, 1'b1);
		settle();
	endtask

	// widest window on a sequence shorter than the half width
	task automatic test_widest_window();
		write_window(CFG_W'(63));
		send_sample(-16'sd32768, 1'b0);
		send_sample(-16'sd32768, 1'b0);
		send_sample(-16'sd32767, 1'b1);
		settle();
	endtask

	task automatic test_extremes();
		write_window(CFG_W'(5));
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd32767, 1'b0);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd32767, 1'b0);
		send_sample(16'sd1, 1'b0);
		send_sample(-16'sd3, 1'b1);
		settle();
	endtask

	// even size acts as the next odd one, on a one-sample sequence
	task automatic test_single_sample();
		write_window(CFG_W'(4));
		send_sample(-16'sd7, 1'b1);
		settle();
	endtask

	task automatic test_window_change();
		write_window(CFG_W'(7));
		send_sample(16'sd100, 1'b0);
		send_sample(-16'sd250, 1'b0);
		send_sample(16'sd32767, 1'b0);
		send_sample(-16'sd5, 1'b0);
		settle();
		write_window(CFG_W'(2));
		send_sample(16'sd9, 1'b0);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd3, 1'b1);
		settle();
	endtask

	// random sequences under one idling mode
	task automatic run_random(input int n_items, input int tx_pct, input int rx_pct);
		int sent;
		int len;
		int half;
		bit paused;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent        = 0;
		paused      = 1'b0;
		while (sent < n_items) begin
			// new window between sequences now and then
			if ($urandom_range(2) == 0) begin
				settle();
				write_window(pick_window());
			end
			half = int'(window_reg) / 2;
			if ($urandom_range(15) == 0)
				len = $urandom_range(80, 60);
			else
				len = $urandom_range(2 * half + 6, 1);
			for (int i = 0; i < len; i++) begin
				send_sample(pick_sample(), i == len - 1);
				sent++;
				// window change in the middle of a sequence
				if (i != len - 1 && $urandom_range(39) == 0) begin
					settle();
					write_window(pick_window());
				end
			end
			// hold off once until the results catch up
			if (!paused && sent >= n_items / 2) begin
				settle();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		in_ch.valid           = 1'b0;
		in_ch.sample          = '0;
		in_ch.end_of_sequence = 1'b0;
		tx_idle_pct           = 0;
		rx_idle_pct           = 0;
		foreach (ring_mem[i])
			ring_mem[i] = '0;
		ring_wr    = 0;
		seq_count  = 0;
		window_reg = CFG_RESET;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_window();
		test_zero_window();
		test_widest_window();
		test_extremes();
		test_single_sample();
		test_window_change();
		run_random(67, 32, 48);
		run_random(67, 48, 32);
		run_random(67, 0, 0);

		settle();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
